### hdl/mnst_pkg.sv
// Shared types and codes for the MIDI note span tracker.
// Used by mnst_cmp_unit, mnst_span_mem and midi_note_span_tracker_core.
package mnst_pkg;

    localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
    localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
    localparam logic [1:0] ACT_ALL_OFF  = 2'd2;
    localparam logic [1:0] ACT_QUERY    = 2'd3;

    localparam int TIME_W = 32;

    // One input request
    typedef struct packed {
        logic [1:0]        action;
        logic [3:0]        channel;
        logic [6:0]        key;
        logic [TIME_W-1:0] time_now;
        logic [TIME_W-1:0] window_begin;
        logic [TIME_W-1:0] window_end;
    } t_req;

    // One result item
    typedef struct packed {
        logic              found;
        logic [3:0]        span_channel;
        logic [6:0]        span_key;
        logic [TIME_W-1:0] span_start;
        logic [TIME_W-1:0] span_stop;
        logic              span_ringing;
        logic              last_of_run;
    } t_rsp;

    // One table entry
    typedef struct packed {
        logic [3:0]        channel;
        logic [6:0]        key;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] stop_time;
        logic              sounding;
    } t_span;

    // Compare unit outcome for the entry under evaluation
    typedef struct packed {
        logic              key_hit;
        logic              overlap;
        logic [TIME_W-1:0] stop_time;
    } t_cmp;

endpackage

### hdl/mnst_cmp_unit.sv
// Shared compare unit: channel/key match and window overlap for one entry.
// Depends on mnst_pkg.
module mnst_cmp_unit (
    input  mnst_pkg::t_span i_span,
    input  mnst_pkg::t_req  i_req,
    output mnst_pkg::t_cmp  o_res
);

    logic [mnst_pkg::TIME_W-1:0] stop_eff;

    // A ringing span ends now
    assign stop_eff = i_span.sounding ? i_req.time_now : i_span.stop_time;

    assign o_res.key_hit   = (i_span.channel == i_req.channel) && (i_span.key == i_req.key);
    assign o_res.overlap   = (stop_eff >= i_req.window_begin) &&
                             (i_span.start_time <= i_req.window_end);
    assign o_res.stop_time = stop_eff;

endmodule

### hdl/mnst_span_mem.sv
// Span table memory: one write port, one read port with registered data.
// Depends on mnst_pkg for the entry type.
module mnst_span_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  mnst_pkg::t_span i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output mnst_pkg::t_span o_rdata
);

    mnst_pkg::t_span r_mem [DEPTH];
    mnst_pkg::t_span r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/midi_note_span_tracker_core.sv
// MIDI note span tracker: note-on writes its entry straight from idle. Note-off, all-off
// and query scan the valid entries through the table's single read port, one entry a
// cycle; a note-off stops at its first match from the newest end, and a query ends
// in a flush state that emits its last result. Output stalls hold the scan.
// Reset (synchronous, active low) clears the pointers and the handshake state;
// the table contents stay undefined and are never read before written.
module midi_note_span_tracker_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mnst_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mnst_pkg::t_rsp o_out_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]      r_state, n_state;
    logic [AW-1:0]   r_wslot, n_wslot;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_left, n_left;
    logic [AW-1:0]   r_rd_slot, n_rd_slot;
    logic [AW-1:0]   r_ev_slot, n_ev_slot;
    logic            r_ev_vld, n_ev_vld;
    logic            r_pend_vld, n_pend_vld;
    logic            r_out_vld, n_out_vld;
    mnst_pkg::t_req  r_req, n_req;
    mnst_pkg::t_rsp  r_pend, n_pend;
    mnst_pkg::t_rsp  r_out, n_out;

    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr;
    mnst_pkg::t_span mem_wdata, mem_rdata;
    mnst_pkg::t_cmp  cmp_res;

    logic            out_free, out_load, stall, hit;
    mnst_pkg::t_rsp  out_next;
    logic [AW-1:0]   slot_up, slot_down, newest, oldest, wslot_up;

    mnst_span_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_rd_slot),
        .o_rdata (mem_rdata)
    );

    mnst_cmp_unit u_cmp (
        .i_span (mem_rdata),
        .i_req  (r_req),
        .o_res  (cmp_res)
    );

    assign slot_up   = (r_rd_slot == AW'(TABLE_DEPTH - 1)) ? '0 : r_rd_slot + AW'(1);
    assign slot_down = (r_rd_slot == '0) ? AW'(TABLE_DEPTH - 1) : r_rd_slot - AW'(1);
    assign wslot_up  = (r_wslot == AW'(TABLE_DEPTH - 1)) ? '0 : r_wslot + AW'(1);
    assign newest    = (r_wslot == '0) ? AW'(TABLE_DEPTH - 1) : r_wslot - AW'(1);
    // Until the table fills, the oldest span sits in slot zero
    assign oldest    = (r_cnt == CW'(TABLE_DEPTH)) ? r_wslot : '0;

    assign out_free  = !r_out_vld || i_out_ready;
    // Hold the scan while a displaced result cannot be handed on
    assign stall     = r_ev_vld && (r_req.action == mnst_pkg::ACT_QUERY) &&
                       cmp_res.overlap && r_pend_vld && !out_free;

    always_comb begin
        n_state    = r_state;
        n_wslot    = r_wslot;
        n_cnt      = r_cnt;
        n_left     = r_left;
        n_rd_slot  = r_rd_slot;
        n_ev_slot  = r_ev_slot;
        n_ev_vld   = r_ev_vld;
        n_pend_vld = r_pend_vld;
        n_req      = r_req;
        n_pend     = r_pend;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = r_ev_slot;
        mem_wdata  = '{channel: mem_rdata.channel, key: mem_rdata.key,
                       start_time: mem_rdata.start_time,
                       stop_time: r_req.time_now, sounding: 1'b0};
        out_load   = 1'b0;
        out_next   = r_pend;
        hit        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req      = i_in_data;
                    n_pend_vld = 1'b0;
                    if (i_in_data.action == mnst_pkg::ACT_NOTE_ON) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_wslot;
                        mem_wdata = '{channel: i_in_data.channel, key: i_in_data.key,
                                      start_time: i_in_data.time_now,
                                      stop_time: i_in_data.time_now, sounding: 1'b1};
                        n_wslot   = wslot_up;
                        if (r_cnt != CW'(TABLE_DEPTH)) begin
                            n_cnt = r_cnt + CW'(1);
                        end
                    end else begin
                        n_state   = S_SCAN;
                        n_left    = r_cnt;
                        n_ev_vld  = 1'b0;
                        n_rd_slot = (i_in_data.action == mnst_pkg::ACT_NOTE_OFF) ?
                                    newest : oldest;
                    end
                end
            end

            S_SCAN: begin
                if (r_ev_vld) begin
                    case (r_req.action)
                        mnst_pkg::ACT_NOTE_OFF: begin
                            if (cmp_res.key_hit) begin
                                mem_we = 1'b1;
                                hit    = 1'b1;
                            end
                        end
                        mnst_pkg::ACT_ALL_OFF: begin
                            mem_we = mem_rdata.sounding;
                        end
                        mnst_pkg::ACT_QUERY: begin
                            if (!stall) begin
                                // Refresh the stop time of a ringing span
                                mem_we    = mem_rdata.sounding;
                                mem_wdata.sounding = 1'b1;
                                if (cmp_res.overlap) begin
                                    if (r_pend_vld) begin
                                        out_load = 1'b1;
                                        out_next = r_pend;
                                    end
                                    n_pend = '{found: 1'b1,
                                               span_channel: mem_rdata.channel,
                                               span_key: mem_rdata.key,
                                               span_start: mem_rdata.start_time,
                                               span_stop: cmp_res.stop_time,
                                               span_ringing: mem_rdata.sounding,
                                               last_of_run: 1'b0};
                                    n_pend_vld = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                if (hit) begin
                    // First match from the newest end closes the note; drop the rest
                    n_state  = S_IDLE;
                    n_ev_vld = 1'b0;
                    n_left   = '0;
                end else if (!stall) begin
                    if (r_left != '0) begin
                        mem_re    = 1'b1;
                        n_ev_vld  = 1'b1;
                        n_ev_slot = r_rd_slot;
                        n_rd_slot = (r_req.action == mnst_pkg::ACT_NOTE_OFF) ?
                                    slot_down : slot_up;
                        n_left    = r_left - CW'(1);
                    end else begin
                        n_ev_vld = 1'b0;
                        if (!r_ev_vld) begin
                            n_state = (r_req.action == mnst_pkg::ACT_QUERY) ?
                                      S_FLUSH : S_IDLE;
                        end
                    end
                end
            end

            S_FLUSH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_pend_vld) begin
                        out_next = r_pend;
                    end else begin
                        out_next = '0;
                    end
                    out_next.last_of_run = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (out_load) begin
            n_out     = out_next;
            n_out_vld = 1'b1;
        end else begin
            n_out     = r_out;
            n_out_vld = r_out_vld && !i_out_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wslot    <= '0;
            r_cnt      <= '0;
            r_left     <= '0;
            r_ev_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wslot    <= n_wslot;
            r_cnt      <= n_cnt;
            r_left     <= n_left;
            r_ev_vld   <= n_ev_vld;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_slot <= n_rd_slot;
        r_ev_slot <= n_ev_slot;
        r_req     <= n_req;
        r_pend    <= n_pend;
        r_out     <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // No entry is under evaluation once the block takes requests again
    a_idle_no_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_ev_vld)
        else $error("entry evaluation pending while idle");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // Before the table wraps, the write slot tracks the entry count
    a_wslot_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != CW'(TABLE_DEPTH)) |-> (r_wslot == AW'(r_cnt)))
        else $error("write slot out of step with entry count");

    a_pend_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> ((r_state != S_IDLE) && (r_req.action == mnst_pkg::ACT_QUERY)))
        else $error("pending result outside a query");

    // A note request never reaches the output
    a_out_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_req.action) == mnst_pkg::ACT_QUERY))
        else $error("result produced by a non-query request");

endmodule

### tb/midi_note_span_tracker_core_tb.sv
`timescale 1ns / 100ps
// Testbench for midi_note_span_tracker_core: directed and random note requests
// checked against an in-bench span table model. Depends on mnst_pkg and the core.
module midi_note_span_tracker_core_tb;

    localparam int DEPTH      = 64;
    localparam int N_RANDOM   = 200;
    localparam int QUIET_LEFT = 30;
    localparam int HOLD_AT    = 80;
    localparam int HOLD_LEN   = 400;

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    logic           i_out_ready = 1'b0;
    mnst_pkg::t_req i_in_data   = '0;
    logic           o_in_ready;
    logic           o_out_valid;
    mnst_pkg::t_rsp o_out_data;

    midi_note_span_tracker_core #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Span table model
    logic [10:0] tbl_ck      [DEPTH];
    logic [31:0] tbl_start   [DEPTH];
    logic [31:0] tbl_stop    [DEPTH];
    logic        tbl_ringing [DEPTH];
    int unsigned wr_ptr  = 0;
    int unsigned n_spans = 0;

    mnst_pkg::t_req pending_reqs[$];
    mnst_pkg::t_rsp span_reports[$];

    int errors     = 0;
    int n_accepted = 0;
    int send_gap   = 0;
    int stall_cnt  = 0;
    int hold_cnt   = 0;
    bit hold_done  = 1'b0;

    // No idling once the run nears its end
    function automatic bit quiet();
        return (pending_reqs.size() < QUIET_LEFT);
    endfunction

    task automatic queue_req(input mnst_pkg::t_req r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Apply one accepted request to the table model and queue the spans it reports
    task automatic track_request(input mnst_pkg::t_req r);
        int unsigned    base;
        int unsigned    s;
        int unsigned    n;
        logic [10:0]    ck;
        bit             have_prev;
        mnst_pkg::t_rsp prev;
        mnst_pkg::t_rsp rsp;
        base      = (wr_ptr + DEPTH - n_spans) % DEPTH;
        ck        = {r.channel, r.key};
        have_prev = 1'b0;
        prev      = '0;
        case (r.action)
            mnst_pkg::ACT_NOTE_ON: begin
                tbl_ck[wr_ptr]      = ck;
                tbl_start[wr_ptr]   = r.time_now;
                tbl_stop[wr_ptr]    = r.time_now;
                tbl_ringing[wr_ptr] = 1'b1;
                wr_ptr = (wr_ptr + 1) % DEPTH;
                if (n_spans < DEPTH) n_spans++;
            end
            mnst_pkg::ACT_NOTE_OFF: begin
                // newest first; a closed span still matches
                for (n = n_spans; n > 0; n--) begin
                    s = (base + n - 1) % DEPTH;
                    if (tbl_ck[s] == ck) begin
                        tbl_stop[s]    = r.time_now;
                        tbl_ringing[s] = 1'b0;
                        break;
                    end
                end
            end
            mnst_pkg::ACT_ALL_OFF: begin
                for (n = 0; n < n_spans; n++) begin
                    s = (base + n) % DEPTH;
                    if (tbl_ringing[s]) begin
                        tbl_stop[s]    = r.time_now;
                        tbl_ringing[s] = 1'b0;
                    end
                end
            end
            mnst_pkg::ACT_QUERY: begin
                for (n = 0; n < n_spans; n++) begin
                    s = (base + n) % DEPTH;
                    if (tbl_ringing[s]) tbl_stop[s] = r.time_now;
                    if (tbl_stop[s] >= r.window_begin && tbl_start[s] <= r.window_end) begin
                        if (have_prev) span_reports.insert(span_reports.size(), prev);
                        rsp.found        = 1'b1;
                        rsp.span_channel = tbl_ck[s][10:7];
                        rsp.span_key     = tbl_ck[s][6:0];
                        rsp.span_start   = tbl_start[s];
                        rsp.span_stop    = tbl_stop[s];
                        rsp.span_ringing = tbl_ringing[s];
                        rsp.last_of_run  = 1'b0;
                        prev      = rsp;
                        have_prev = 1'b1;
                    end
                end
                // mark the final span, or report an empty window
                prev.last_of_run = 1'b1;
                span_reports.insert(span_reports.size(), prev);
            end
            default: begin
            end
        endcase
    endtask

    function automatic mnst_pkg::t_req mk_req(input logic [1:0] action,
                                              input logic [3:0] chan,
                                              input logic [6:0] key, input logic [31:0] now,
                                              input logic [31:0] wbeg,
                                              input logic [31:0] wend);
        mnst_pkg::t_req r;
        r.action       = action;
        r.channel      = chan;
        r.key          = key;
        r.time_now     = now;
        r.window_begin = wbeg;
        r.window_end   = wend;
        return r;
    endfunction

    // Stimulus
    initial begin
        int             i;
        int             sel;
        logic [31:0]    tick;
        mnst_pkg::t_req r;
        tick = 32'd500;
        queue_req(mk_req(mnst_pkg::ACT_QUERY,    4'd0,  7'd0,   32'd0,  32'd0, 32'hFFFF_FFFF));
        queue_req(mk_req(mnst_pkg::ACT_NOTE_ON,  4'd0,  7'd0,   32'd0,  32'd0, 32'd0));
        queue_req(mk_req(mnst_pkg::ACT_NOTE_ON,  4'd15, 7'd127, 32'hFFFF_FFF0, 32'd0, 32'd0));
        queue_req(mk_req(mnst_pkg::ACT_NOTE_ON,  4'd15, 7'd127, 32'd100, 32'd0, 32'd0));
        queue_req(mk_req(mnst_pkg::ACT_NOTE_ON,  4'd9,  7'd64,  32'd120, 32'd0, 32'd0));
        queue_req(mk_req(mnst_pkg::ACT_NOTE_OFF, 4'd3,  7'd5,   32'd130, 32'd0, 32'd0));
        queue_req(mk_req(mnst_pkg::ACT_NOTE_OFF, 4'd15, 7'd127, 32'd150, 32'd0, 32'd0));
        queue_req(mk_req(mnst_pkg::ACT_NOTE_OFF, 4'd15, 7'd127, 32'd160, 32'd0, 32'd0));
        queue_req(mk_req(mnst_pkg::ACT_QUERY,    4'd0,  7'd0,   32'd200, 32'd0, 32'hFFFF_FFFF));
        queue_req(mk_req(mnst_pkg::ACT_QUERY,    4'd0,  7'd0,   32'd210, 32'hFFFF_FFFF, 32'd0));
        queue_req(mk_req(mnst_pkg::ACT_QUERY,    4'd0,  7'd0,   32'd220, 32'd130, 32'd140));
        queue_req(mk_req(mnst_pkg::ACT_QUERY,    4'd0,  7'd0,   32'd230, 32'hFFFF_FFF0,
                         32'hFFFF_FFFF));
        queue_req(mk_req(mnst_pkg::ACT_ALL_OFF,  4'd0,  7'd0,   32'd300, 32'd0, 32'd0));
        queue_req(mk_req(mnst_pkg::ACT_ALL_OFF,  4'd0,  7'd0,   32'd310, 32'd0, 32'd0));
        queue_req(mk_req(mnst_pkg::ACT_QUERY,    4'd0,  7'd0,   32'd400, 32'd300, 32'd300));
        queue_req(mk_req(mnst_pkg::ACT_NOTE_ON,  4'd15, 7'd127, 32'hFFFF_FFFF, 32'd0, 32'd0));
        queue_req(mk_req(mnst_pkg::ACT_QUERY,    4'd0,  7'd0,   32'd0,  32'd0, 32'hFFFF_FFFF));
        queue_req(mk_req(mnst_pkg::ACT_NOTE_OFF, 4'd15, 7'd127, 32'd5,  32'd0, 32'd0));
        queue_req(mk_req(mnst_pkg::ACT_QUERY,    4'd0,  7'd0,   32'd6,  32'd0, 32'hFFFF_FFFF));

        for (i = 0; i < N_RANDOM; i++) begin
            tick = tick + $urandom_range(0, 40);
            if ($urandom_range(0, 19) == 0) tick = $urandom;
            r.time_now     = tick;
            r.window_begin = $urandom;
            r.window_end   = $urandom;
            // mostly a small pool of notes so that note-offs find their spans
            if ($urandom_range(0, 3) == 0) begin
                r.channel = 4'($urandom);
                r.key     = 7'($urandom);
            end else begin
                r.channel = 4'($urandom_range(0, 3));
                r.key     = 7'(60 + $urandom_range(0, 7));
            end
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                r.action = mnst_pkg::ACT_NOTE_ON;
            end else if (sel < 68) begin
                r.action = mnst_pkg::ACT_NOTE_OFF;
            end else if (sel < 73) begin
                r.action = mnst_pkg::ACT_ALL_OFF;
            end else begin
                r.action = mnst_pkg::ACT_QUERY;
                case ($urandom_range(0, 3))
                    0: begin
                        r.window_begin = 32'd0;
                        r.window_end   = 32'hFFFF_FFFF;
                    end
                    1: begin
                        r.window_begin = tick - $urandom_range(0, 400);
                        r.window_end   = r.window_begin + $urandom_range(0, 200);
                    end
                    2: ;
                    default: begin
                        r.window_begin = tick;
                        r.window_end   = tick - $urandom_range(1, 300);
                    end
                endcase
            end
            queue_req(r);
        end
    end

    // Request driver
    always @(posedge i_clk) begin
        logic           nxt_valid;
        mnst_pkg::t_req nxt_data;
        nxt_valid = i_in_valid;
        nxt_data  = i_in_data;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                track_request(i_in_data);
                n_accepted++;
                nxt_valid = 1'b0;
                if (!quiet() && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 17);
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_reqs.size() > 0) begin
                    nxt_data  = pending_reqs.pop_front();
                    nxt_valid = 1'b1;
                end
            end
        end
        i_in_valid <= nxt_valid;
        i_in_data  <= nxt_data;
    end

    // Result receiver: random stalls plus one long hold to back up the core
    always @(posedge i_clk) begin
        logic nxt_ready;
        if (!hold_done && n_accepted >= HOLD_AT) begin
            hold_cnt  = HOLD_LEN;
            hold_done = 1'b1;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            nxt_ready = 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt--;
            nxt_ready = 1'b0;
        end else begin
            nxt_ready = 1'b1;
            if (!quiet() && $urandom_range(0, 4) == 0) stall_cnt = $urandom_range(1, 17);
        end
        i_out_ready <= nxt_ready;
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Result monitor
    always @(posedge i_clk) begin
        mnst_pkg::t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (span_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, o_out_data);
                errors++;
            end else begin
                want = span_reports.pop_front();
                compare_field("found", 32'(want.found), 32'(o_out_data.found));
                compare_field("span_channel", 32'(want.span_channel),
                              32'(o_out_data.span_channel));
                compare_field("span_key", 32'(want.span_key), 32'(o_out_data.span_key));
                compare_field("span_start", want.span_start, o_out_data.span_start);
                compare_field("span_stop", want.span_stop, o_out_data.span_stop);
                compare_field("span_ringing", 32'(want.span_ringing),
                              32'(o_out_data.span_ringing));
                compare_field("last_of_run", 32'(want.last_of_run),
                              32'(o_out_data.last_of_run));
            end
        end
    end

    // End of run
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (pending_reqs.size() > 0 || i_in_valid) @(posedge i_clk);
        while (span_reports.size() > 0) @(posedge i_clk);
        // let a full table scan finish so stray results show up
        repeat (DEPTH + 20) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
